// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: src/ptb_pkg.sv
// ---------------------------------------------------------------------------
// ptb_pkg
// Shared constants for the palindromic tree builder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptb_pkg;

    localparam int MAX_TEXT_DEF = 1024;
    localparam int ALPHABET_DEF = 26;
    localparam int EVEN_ROOT    = 0;
    localparam int ODD_ROOT     = 1;
    localparam int ROOT_COUNT   = 2;

endpackage

// File: src/ptb_ram.sv
// ---------------------------------------------------------------------------
// ptb_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/ptb_fits.sv
// ---------------------------------------------------------------------------
// ptb_fits
// Shared compare unit: position of the letter before a palindrome and match.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptb_fits #(
    parameter int TA_W     = 10,
    parameter int NODE_W   = 11,
    parameter int LETTER_W = 5
) (
    input  logic [TA_W-1:0]     pos,
    input  logic [NODE_W-1:0]   len,
    input  logic [LETTER_W-1:0] text_q,
    input  logic [LETTER_W-1:0] letter,
    output logic [TA_W-1:0]     at,
    output logic                at_ok,
    output logic                match
);

    logic [NODE_W:0] diff;

    // pos - len - 1, sign bit marks the never-matching position before the text
    assign diff  = (NODE_W+1)'(pos) - (NODE_W+1)'(len) - (NODE_W+1)'(1);
    assign at_ok = ~diff[NODE_W];
    assign at    = diff[TA_W-1:0];
    assign match = (text_q == letter);

endmodule

// File: src/palindromic_tree_builder.sv
// ---------------------------------------------------------------------------
// palindromic_tree_builder
// Online palindromic tree (eertree) over a letter stream.
//
//  channel  ports                                   dir  moves
//  s_       s_valid s_ready s_letter s_restart      in   one letter item
//  m_       m_valid m_ready m_suffix_node ...       out  one result item
//
// One item at a time; s_ready is high only in idle, entered as the result loads.
// After accept the letter is checked, then the walk reads each node's length and
// compares the text letter where its position lies in the text, ending at the odd
// root or a match. A new node needs a second walk from the parent's link unless
// that is the odd root. A rejected letter skips to the count read and output.
// After reset, and for an item with restart set, the (MAX_TEXT+2)*ALPHABET child
// entries (26676) are zeroed. A waiting result holds up only the next result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module palindromic_tree_builder
    import ptb_pkg::*;
#(
    parameter int MAX_TEXT = MAX_TEXT_DEF,
    parameter int ALPHABET = ALPHABET_DEF,
    localparam int NODE_CAP = MAX_TEXT + 2,
    localparam int NODE_W   = $clog2(MAX_TEXT + 3),
    localparam int LETTER_W = $clog2(ALPHABET)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [LETTER_W-1:0] s_letter,
    input  logic                s_restart,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [NODE_W-1:0]   m_suffix_node,
    output logic [NODE_W-1:0]   m_suffix_len,
    output logic                m_created,
    output logic [NODE_W-1:0]   m_end_count,
    output logic [NODE_W-1:0]   m_node_total,
    output logic                m_overflow
);

    localparam int TA_W      = $clog2(MAX_TEXT);
    localparam int TEXT_W    = $clog2(MAX_TEXT + 1);
    localparam int NA_W      = $clog2(NODE_CAP);
    localparam int CH_DEPTH  = NODE_CAP * ALPHABET;
    localparam int CH_AW     = $clog2(CH_DEPTH);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_CLEAR    = 14'b00000000000010,
        S_CHECK    = 14'b00000000000100,
        S_WALK_RD  = 14'b00000000001000,
        S_WALK_LEN = 14'b00000000010000,
        S_WALK_TXT = 14'b00000000100000,
        S_CHILD_RD = 14'b00000001000000,
        S_CHILD_CK = 14'b00000010000000,
        S_CREATE   = 14'b00000100000000,
        S_OCC_RD   = 14'b00001000000000,
        S_OCC_WR   = 14'b00010000000000,
        S_OUT      = 14'b00100000000000,
        S_SPARE0   = 14'b01000000000000,
        S_SPARE1   = 14'b10000000000000
    } state_t;

    state_t              state_reg;
    logic [CH_AW-1:0]    clr_cnt_reg;
    logic                item_reg;
    logic [LETTER_W-1:0] c_reg;
    logic [TEXT_W-1:0]   text_len_reg;
    logic [NODE_W-1:0]   nodes_reg;
    logic [NODE_W-1:0]   cur_reg;
    logic [NODE_W-1:0]   v_reg;
    logic [NODE_W-1:0]   p_reg;
    logic [NODE_W-1:0]   plen_reg;
    logic [NODE_W-1:0]   plink_reg;
    logic [NODE_W-1:0]   len_reg;
    logic [NODE_W-1:0]   link_reg;
    logic [NODE_W-1:0]   new_link_reg;
    logic                phase_reg;
    logic                created_reg;
    logic                ovf_reg;
    logic [TA_W-1:0]     pos_reg;
    logic [NODE_W-1:0]   res_len_reg;
    logic [NODE_W-1:0]   res_occ_reg;
    logic                m_valid_reg;
    logic [NODE_W-1:0]   m_node_reg;
    logic [NODE_W-1:0]   m_len_reg;
    logic                m_created_reg;
    logic [NODE_W-1:0]   m_occ_reg;
    logic [NODE_W-1:0]   m_total_reg;
    logic                m_ovf_reg;

    logic                text_we;
    logic [TA_W-1:0]     text_waddr;
    logic [TA_W-1:0]     text_raddr;
    logic [LETTER_W-1:0] text_q;
    logic                node_we;
    logic [NA_W-1:0]     node_waddr;
    logic [NA_W-1:0]     node_raddr;
    logic [NODE_W-1:0]   len_wdata;
    logic [NODE_W-1:0]   len_q;
    logic [NODE_W-1:0]   link_q;
    logic                occ_we;
    logic [NODE_W-1:0]   occ_wdata;
    logic [NODE_W-1:0]   occ_q;
    logic                ch_we;
    logic [CH_AW-1:0]    ch_waddr;
    logic [NODE_W-1:0]   ch_wdata;
    logic [CH_AW-1:0]    ch_raddr;
    logic [NODE_W-1:0]   ch_q;

    logic [NODE_W-1:0]   len_v;
    logic [NODE_W-1:0]   link_v;
    logic [TA_W-1:0]     fit_at;
    logic                fit_ok;
    logic                fit_match;
    logic                walk_done;
    logic                reject;
    logic                cur_root;
    logic [NODE_W-1:0]   cur_len;
    logic [NODE_W-1:0]   cur_occ;
    logic [NODE_W-1:0]   occ_new;
    logic [NODE_W-1:0]   new_len;
    logic [CH_AW-1:0]    slot_v;
    logic [CH_AW-1:0]    slot_p;
    logic                out_free;

    ptb_ram #(.WIDTH(LETTER_W), .DEPTH(MAX_TEXT)) u_text_ram (
        .aclk (aclk), .we (text_we), .waddr (text_waddr), .wdata (c_reg),
        .raddr (text_raddr), .rdata (text_q)
    );

    ptb_ram #(.WIDTH(NODE_W), .DEPTH(NODE_CAP)) u_len_ram (
        .aclk (aclk), .we (node_we), .waddr (node_waddr), .wdata (len_wdata),
        .raddr (node_raddr), .rdata (len_q)
    );

    ptb_ram #(.WIDTH(NODE_W), .DEPTH(NODE_CAP)) u_link_ram (
        .aclk (aclk), .we (node_we), .waddr (node_waddr), .wdata (new_link_reg),
        .raddr (node_raddr), .rdata (link_q)
    );

    ptb_ram #(.WIDTH(NODE_W), .DEPTH(NODE_CAP)) u_occ_ram (
        .aclk (aclk), .we (occ_we), .waddr (cur_reg[NA_W-1:0]), .wdata (occ_wdata),
        .raddr (node_raddr), .rdata (occ_q)
    );

    ptb_ram #(.WIDTH(NODE_W), .DEPTH(CH_DEPTH)) u_child_ram (
        .aclk (aclk), .we (ch_we), .waddr (ch_waddr), .wdata (ch_wdata),
        .raddr (ch_raddr), .rdata (ch_q)
    );

    ptb_fits #(.TA_W(TA_W), .NODE_W(NODE_W), .LETTER_W(LETTER_W)) u_fits (
        .pos (pos_reg), .len (len_v), .text_q (text_q), .letter (c_reg),
        .at (fit_at), .at_ok (fit_ok), .match (fit_match)
    );

    assign len_v  = (v_reg == NODE_W'(EVEN_ROOT)) ? '0 : len_q;
    assign link_v = (v_reg < NODE_W'(ROOT_COUNT)) ? NODE_W'(ODD_ROOT) : link_q;
    assign slot_v = CH_AW'(v_reg) * CH_AW'(ALPHABET) + CH_AW'(c_reg);
    assign slot_p = CH_AW'(p_reg) * CH_AW'(ALPHABET) + CH_AW'(c_reg);
    assign new_len = (p_reg == NODE_W'(ODD_ROOT)) ? NODE_W'(1) : plen_reg + NODE_W'(2);
    assign reject = ({1'b0, c_reg} >= (LETTER_W+1)'(ALPHABET))
                 || (text_len_reg >= TEXT_W'(MAX_TEXT))
                 || (nodes_reg >= NODE_W'(NODE_CAP));
    assign walk_done = ((state_reg == S_WALK_RD) && (v_reg == NODE_W'(ODD_ROOT)))
                    || ((state_reg == S_WALK_TXT) && fit_match);
    assign cur_root = (cur_reg < NODE_W'(ROOT_COUNT));
    assign cur_len  = cur_root ? '0 : len_q;
    assign cur_occ  = cur_root ? '0 : occ_q;
    assign occ_new  = created_reg ? NODE_W'(1) : cur_occ + NODE_W'(1);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        text_we    = 1'b0;
        text_waddr = text_len_reg[TA_W-1:0];
        text_raddr = fit_at;
        node_we    = 1'b0;
        node_waddr = nodes_reg[NA_W-1:0];
        node_raddr = v_reg[NA_W-1:0];
        len_wdata  = new_len;
        occ_we     = 1'b0;
        occ_wdata  = occ_new;
        ch_we      = 1'b0;
        ch_waddr   = clr_cnt_reg;
        ch_wdata   = '0;
        ch_raddr   = slot_v;
        if (state_reg == S_CHECK) begin
            text_we = !reject;
        end
        if (state_reg == S_CLEAR) begin
            ch_we = 1'b1;
        end
        if (state_reg == S_CREATE) begin
            node_we  = 1'b1;
            ch_we    = 1'b1;
            ch_waddr = slot_p;
            ch_wdata = nodes_reg;
        end
        if (state_reg == S_OCC_RD) begin
            node_raddr = cur_reg[NA_W-1:0];
        end
        if (state_reg == S_OCC_WR) begin
            occ_we = !ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            item_reg     <= 1'b0;
            text_len_reg <= '0;
            nodes_reg    <= NODE_W'(ROOT_COUNT);
            cur_reg      <= NODE_W'(EVEN_ROOT);
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        c_reg       <= s_letter;
                        created_reg <= 1'b0;
                        ovf_reg     <= 1'b0;
                        if (s_restart) begin
                            text_len_reg <= '0;
                            nodes_reg    <= NODE_W'(ROOT_COUNT);
                            cur_reg      <= NODE_W'(EVEN_ROOT);
                            clr_cnt_reg  <= '0;
                            item_reg     <= 1'b1;
                            state_reg    <= S_CLEAR;
                        end else begin
                            state_reg <= S_CHECK;
                        end
                    end
                end
                S_CLEAR: begin
                    if (clr_cnt_reg == CH_AW'(CH_DEPTH - 1)) begin
                        item_reg  <= 1'b0;
                        state_reg <= item_reg ? S_CHECK : S_IDLE;
                    end else begin
                        clr_cnt_reg <= clr_cnt_reg + CH_AW'(1);
                    end
                end
                S_CHECK: begin
                    if (reject) begin
                        ovf_reg   <= 1'b1;
                        state_reg <= S_OCC_RD;
                    end else begin
                        pos_reg      <= text_len_reg[TA_W-1:0];
                        text_len_reg <= text_len_reg + TEXT_W'(1);
                        v_reg        <= cur_reg;
                        phase_reg    <= 1'b0;
                        state_reg    <= S_WALK_RD;
                    end
                end
                S_WALK_RD: begin
                    if (!walk_done) begin
                        state_reg <= S_WALK_LEN;
                    end
                end
                S_WALK_LEN: begin
                    len_reg  <= len_v;
                    link_reg <= link_v;
                    if (fit_ok) begin
                        state_reg <= S_WALK_TXT;
                    end else begin
                        v_reg     <= link_v;
                        state_reg <= S_WALK_RD;
                    end
                end
                S_WALK_TXT: begin
                    if (!fit_match) begin
                        v_reg     <= link_reg;
                        state_reg <= S_WALK_RD;
                    end
                end
                S_CHILD_RD: begin
                    state_reg <= S_CHILD_CK;
                end
                S_CHILD_CK: begin
                    if (phase_reg) begin
                        new_link_reg <= ch_q;
                        state_reg    <= S_CREATE;
                    end else if (ch_q != '0) begin
                        cur_reg   <= ch_q;
                        state_reg <= S_OCC_RD;
                    end else if (p_reg == NODE_W'(ODD_ROOT)) begin
                        new_link_reg <= NODE_W'(EVEN_ROOT);
                        state_reg    <= S_CREATE;
                    end else begin
                        phase_reg <= 1'b1;
                        v_reg     <= plink_reg;
                        state_reg <= S_WALK_RD;
                    end
                end
                S_CREATE: begin
                    cur_reg     <= nodes_reg;
                    nodes_reg   <= nodes_reg + NODE_W'(1);
                    created_reg <= 1'b1;
                    state_reg   <= S_OCC_RD;
                end
                S_OCC_RD: begin
                    state_reg <= S_OCC_WR;
                end
                S_OCC_WR: begin
                    res_len_reg <= cur_len;
                    res_occ_reg <= ovf_reg ? cur_occ : occ_new;
                    state_reg   <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_node_reg    <= cur_reg;
                        m_len_reg     <= res_len_reg;
                        m_created_reg <= created_reg;
                        m_occ_reg     <= res_occ_reg;
                        m_total_reg   <= nodes_reg;
                        m_ovf_reg     <= ovf_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (walk_done) begin
                state_reg <= S_CHILD_RD;
                if (!phase_reg) begin
                    p_reg     <= v_reg;
                    plen_reg  <= len_reg;
                    plink_reg <= link_reg;
                end
            end
        end
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_suffix_node = m_node_reg;
    assign m_suffix_len  = m_len_reg;
    assign m_created     = m_created_reg;
    assign m_end_count   = m_occ_reg;
    assign m_node_total  = m_total_reg;
    assign m_overflow    = m_ovf_reg;

    `ASSERT_NEVER(a_nodes_cap, aclk, aresetn, nodes_reg > NODE_W'(NODE_CAP))
    `ASSERT_NEVER(a_text_cap, aclk, aresetn, text_len_reg > TEXT_W'(MAX_TEXT))
    `ASSERT_AT(a_created_last, aclk, aresetn, (m_valid && m_created) |-> (m_suffix_node == m_node_total - NODE_W'(1)))
    `ASSERT_AT(a_ovf_no_create, aclk, aresetn, (m_valid && m_overflow) |-> !m_created)

endmodule
